// File: hw/rtl/plane_grid_mesh_generator_top_defines.svh
// assertion macros shared by the plane grid mesh generator rtl
`ifndef PLANE_GRID_MESH_GENERATOR_TOP_DEFINES_SVH
`define PLANE_GRID_MESH_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define PGM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PGM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pgm_pkg.sv
// types, codes and constants of the plane grid mesh generator
package pgm_pkg;

  localparam int SEG_W   = 8;
  localparam int GRID_W  = SEG_W + 1;
  localparam int CFG_W   = 32;
  localparam int REG_IDX_W = 2;
  localparam int UV_W    = 17;
  localparam int IDX_W   = 16;
  localparam int KIND_W  = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PLANE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SEGMENTS_X   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SEGMENTS_Y   = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_VERTEX   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd2;

  // divider step counts: full word, or a dividend below 2^25
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LONG  = 6'd32;
  localparam logic [DIV_CNT_W-1:0] DIV_SHORT = 6'd25;
  localparam int DIV_SKIP = 32 - 25;

  localparam logic [UV_W-1:0] UV_ONE = 17'h10000;

  typedef struct packed {
    logic             start;
    logic             short_op;
    logic [CFG_W-1:0] num;
    logic [SEG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CFG_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0] item_kind;
    logic [31:0]       pos_x;
    logic [31:0]       pos_y;
    logic [UV_W-1:0]   tex_u;
    logic [UV_W-1:0]   tex_v;
    logic [IDX_W-1:0]  corner_first;
    logic [IDX_W-1:0]  corner_second;
    logic [IDX_W-1:0]  corner_third;
    logic              mesh_last;
  } mesh_item_t;

endpackage

// File: hw/rtl/pgm_ctl_if.sv
// request channel: restart or advance
interface pgm_ctl_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// File: hw/rtl/pgm_mesh_if.sv
// result channel: one vertex, triangle or done marker per transfer
interface pgm_mesh_if;
  import pgm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        item_kind;
  logic signed [31:0]       pos_x;
  logic signed [31:0]       pos_y;
  logic [UV_W-1:0]          tex_u;
  logic [UV_W-1:0]          tex_v;
  logic [IDX_W-1:0]         corner_first;
  logic [IDX_W-1:0]         corner_second;
  logic [IDX_W-1:0]         corner_third;
  logic                     mesh_last;

  modport source (output valid, output item_kind, output pos_x, output pos_y,
                  output tex_u, output tex_v, output corner_first,
                  output corner_second, output corner_third, output mesh_last,
                  input ready);
  modport sink (input valid, input item_kind, input pos_x, input pos_y,
                input tex_u, input tex_v, input corner_first,
                input corner_second, input corner_third, input mesh_last,
                output ready);
endinterface

// File: hw/rtl/pgm_div.sv
// bit-serial restoring divider, 32-bit dividend by 8-bit divisor
`include "plane_grid_mesh_generator_top_defines.svh"

module pgm_div (
  input  logic              clk,
  input  logic              rst,
  input  pgm_pkg::div_req_t req,
  output pgm_pkg::div_rsp_t rsp
);
  import pgm_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CFG_W-1:0]     num_sh;
  logic [CFG_W-1:0]     quo;
  logic [SEG_W-1:0]     rem;
  logic [SEG_W-1:0]     den;
  logic [SEG_W:0]       trial;
  logic                 fits;

  assign trial = {rem, num_sh[CFG_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        // short dividends skip their leading zero bits
        num_sh <= req.short_op ? (req.num << DIV_SKIP) : req.num;
        cnt    <= req.short_op ? DIV_SHORT : DIV_LONG;
        rem    <= '0;
        quo    <= '0;
        den    <= req.den;
      end else if (busy) begin
        rem    <= fits ? SEG_W'(trial - {1'b0, den}) : trial[SEG_W-1:0];
        quo    <= {quo[CFG_W-2:0], fits};
        num_sh <= num_sh << 1;
        cnt    <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

  `PGM_ASSERT_IMPLY(a_rem_below_den, busy, rem < den, "partial remainder not below divisor")
  `PGM_ASSERT_IMPLY(a_no_start_busy, req.start, !busy, "divide started while busy")
  `PGM_ASSERT_NEXT(a_start_runs, req.start, busy && !done, "divide did not start")

endmodule

// File: hw/rtl/plane_grid_mesh_generator_top.sv
// Plane grid mesh generator. Each transfer on ctl (restart=1 restarts at the
// first vertex, restart=0 advances) yields exactly one transfer on mesh: first
// the (sx+1)*(sy+1) vertices in row-major order with Q16.16 position and Q1.16
// texture coordinates, then two triangles per cell, then a done marker until
// restart. Segment counts of zero act as one. All divisions run on one shared
// bit-serial divider: a vertex needs two 25-step divides for u and v, and the
// first vertex after any register write first recomputes the segment sizes
// with two 32-step divides. Triangles and done markers use no divide. A
// finished result sits in an output register, so a new request is taken while
// it waits. Registers may be written only while the block is idle.
`include "plane_grid_mesh_generator_top_defines.svh"

module plane_grid_mesh_generator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [pgm_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [pgm_pkg::CFG_W-1:0]       wr_data,
  pgm_ctl_if.sink                         ctl,
  pgm_mesh_if.source                      mesh
);
  import pgm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SEGW, S_SEGH, S_DIVU, S_DIVV, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_VERT, PH_TRI, PH_DONE
  } phase_t;

  // configuration
  logic [CFG_W-1:0] plane_width;
  logic [CFG_W-1:0] plane_height;
  logic [SEG_W-1:0] segments_x;
  logic [SEG_W-1:0] segments_y;
  logic             dirty;

  // sequencer and walk state
  state_t            state;
  logic [1:0]        phase;
  logic [GRID_W-1:0] column;
  logic [GRID_W-1:0] row;
  logic              second_half;
  logic [GRID_W-1:0] wcol;
  logic [GRID_W-1:0] wrow;
  logic [CFG_W-1:0]  segw;
  logic [CFG_W-1:0]  segh;
  mesh_item_t        res;
  mesh_item_t        out_reg;
  logic              out_valid;

  div_req_t div_req;
  div_rsp_t div_rsp;

  pgm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // grid extents and request normalization
  logic [SEG_W-1:0]  gx;
  logic [SEG_W-1:0]  gy;
  logic [GRID_W-1:0] gx9;
  logic [GRID_W-1:0] gy9;
  logic [GRID_W-1:0] gx1;
  logic [1:0]        ph_a;
  logic [GRID_W-1:0] col_a;
  logic [GRID_W-1:0] row_a;
  logic              sh_a;
  logic [1:0]        ph_b;
  logic [GRID_W-1:0] col_b;
  logic [GRID_W-1:0] row_b;
  logic              sh_b;
  logic [1:0]        ph_c;
  logic [17:0]       a_full;
  logic [17:0]       b_full;
  logic [IDX_W-1:0]  ca;
  logic [IDX_W-1:0]  cb;
  logic              col_end;
  logic              row_end;
  logic              last_cell;
  logic [40:0]       px_prod;
  logic [40:0]       py_prod;
  logic              accept;

  always_comb begin
    gx  = (segments_x == '0) ? SEG_W'(1) : segments_x;
    gy  = (segments_y == '0) ? SEG_W'(1) : segments_y;
    gx9 = {1'b0, gx};
    gy9 = {1'b0, gy};
    gx1 = gx9 + GRID_W'(1);

    ph_a  = ctl.restart ? PH_VERT : phase;
    col_a = ctl.restart ? '0 : column;
    row_a = ctl.restart ? '0 : row;
    sh_a  = ctl.restart ? 1'b0 : second_half;

    // vertex walk past a shrunk grid falls through to triangles
    if (ph_a == PH_VERT && (col_a > gx9 || row_a > gy9)) begin
      ph_b  = PH_TRI;
      col_b = '0;
      row_b = '0;
      sh_b  = 1'b0;
    end else begin
      ph_b  = ph_a;
      col_b = col_a;
      row_b = row_a;
      sh_b  = sh_a;
    end
    ph_c = (ph_b == PH_TRI && (col_b >= gx9 || row_b >= gy9)) ? PH_DONE : ph_b;

    a_full    = 18'(col_b) + 18'(gx1) * 18'(row_b);
    b_full    = a_full + 18'(gx1);
    ca        = a_full[IDX_W-1:0];
    cb        = b_full[IDX_W-1:0];
    col_end   = (10'(col_b) + 10'd1) >= 10'(gx);
    row_end   = (10'(row_b) + 10'd1) >= 10'(gy);
    last_cell = col_end && row_end;

    px_prod = 41'(wcol) * 41'(segw);
    py_prod = 41'(wrow) * 41'(segh);
  end

  assign ctl.ready = (state == S_IDLE) && !rst;
  assign accept    = ctl.valid && ctl.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_width   <= 32'h0001_0000;
      plane_height  <= 32'h0001_0000;
      segments_x    <= SEG_W'(1);
      segments_y    <= SEG_W'(1);
      dirty         <= 1'b1;
      state         <= S_IDLE;
      phase         <= PH_VERT;
      column        <= '0;
      row           <= '0;
      second_half   <= 1'b0;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;

      if (wr_en) begin
        dirty <= 1'b1;
        unique case (wr_index)
          REG_PLANE_WIDTH:  plane_width  <= wr_data;
          REG_PLANE_HEIGHT: plane_height <= wr_data;
          REG_SEGMENTS_X:   segments_x   <= wr_data[SEG_W-1:0];
          REG_SEGMENTS_Y:   segments_y   <= wr_data[SEG_W-1:0];
        endcase
      end

      if (mesh.valid && mesh.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res <= '0;
            case (ph_c)
              PH_VERT: begin
                res.item_kind <= KIND_VERTEX;
                wcol          <= col_b;
                wrow          <= row_b;
                second_half   <= sh_b;
                if (col_b >= gx9) begin
                  column <= '0;
                  if (row_b >= gy9) begin
                    phase       <= PH_TRI;
                    row         <= '0;
                    second_half <= 1'b0;
                  end else begin
                    phase <= PH_VERT;
                    row   <= row_b + GRID_W'(1);
                  end
                end else begin
                  phase  <= PH_VERT;
                  column <= col_b + GRID_W'(1);
                  row    <= row_b;
                end
                div_req.start <= 1'b1;
                if (dirty) begin
                  div_req.short_op <= 1'b0;
                  div_req.num      <= plane_width;
                  div_req.den      <= gx;
                  state            <= S_SEGW;
                end else begin
                  div_req.short_op <= 1'b1;
                  div_req.num      <= {7'b0, col_b, 16'b0};
                  div_req.den      <= gx;
                  state            <= S_DIVU;
                end
              end
              PH_TRI: begin
                res.item_kind <= KIND_TRIANGLE;
                column        <= col_b;
                row           <= row_b;
                phase         <= PH_TRI;
                if (!sh_b) begin
                  res.corner_first  <= ca;
                  res.corner_second <= cb;
                  res.corner_third  <= ca + IDX_W'(1);
                  second_half       <= 1'b1;
                end else begin
                  res.corner_first  <= cb;
                  res.corner_second <= cb + IDX_W'(1);
                  res.corner_third  <= ca + IDX_W'(1);
                  second_half       <= 1'b0;
                  if (last_cell) begin
                    res.mesh_last <= 1'b1;
                    phase         <= PH_DONE;
                  end else if (col_end) begin
                    column <= '0;
                    row    <= row_b + GRID_W'(1);
                  end else begin
                    column <= col_b + GRID_W'(1);
                  end
                end
                state <= S_FIN;
              end
              default: begin
                res.item_kind <= KIND_DONE;
                phase         <= PH_DONE;
                column        <= col_b;
                row           <= row_b;
                second_half   <= sh_b;
                state         <= S_FIN;
              end
            endcase
          end
        end
        S_SEGW: begin
          if (div_rsp.done) begin
            segw             <= div_rsp.quo;
            div_req.start    <= 1'b1;
            div_req.short_op <= 1'b0;
            div_req.num      <= plane_height;
            div_req.den      <= gy;
            state            <= S_SEGH;
          end
        end
        S_SEGH: begin
          if (div_rsp.done) begin
            segh             <= div_rsp.quo;
            dirty            <= 1'b0;
            div_req.start    <= 1'b1;
            div_req.short_op <= 1'b1;
            div_req.num      <= {7'b0, wcol, 16'b0};
            div_req.den      <= gx;
            state            <= S_DIVU;
          end
        end
        S_DIVU: begin
          if (div_rsp.done) begin
            res.tex_u        <= div_rsp.quo[UV_W-1:0];
            div_req.start    <= 1'b1;
            div_req.short_op <= 1'b1;
            div_req.num      <= {7'b0, wrow, 16'b0};
            div_req.den      <= gy;
            state            <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (div_rsp.done) begin
            res.tex_v <= UV_ONE - div_rsp.quo[UV_W-1:0];
            res.pos_x <= px_prod[31:0] - {1'b0, plane_width[31:1]};
            res.pos_y <= {1'b0, plane_height[31:1]} - py_prod[31:0];
            state     <= S_FIN;
          end
        end
        S_FIN: begin
          // wait until the output register is free or being drained
          if (!out_valid || mesh.ready) begin
            out_reg   <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mesh.valid         = out_valid;
  assign mesh.item_kind     = out_reg.item_kind;
  assign mesh.pos_x         = out_reg.pos_x;
  assign mesh.pos_y         = out_reg.pos_y;
  assign mesh.tex_u         = out_reg.tex_u;
  assign mesh.tex_v         = out_reg.tex_v;
  assign mesh.corner_first  = out_reg.corner_first;
  assign mesh.corner_second = out_reg.corner_second;
  assign mesh.corner_third  = out_reg.corner_third;
  assign mesh.mesh_last     = out_reg.mesh_last;

  `PGM_ASSERT_IMPLY(a_vertex_not_last, mesh.valid && mesh.item_kind == KIND_VERTEX, !mesh.mesh_last, "vertex flagged as last")
  `PGM_ASSERT_NEXT(a_fin_loads, state == S_FIN && !out_valid, out_valid && state == S_IDLE, "result not loaded")
  `PGM_ASSERT_IMPLY(a_idle_div_free, ctl.ready, !div_rsp.busy, "divider busy while taking requests")

endmodule
